### hdl/nqse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nqse_pkg
// Shared constants and types of the N-queens solution enumerator.
// ----------------------------------------------------------------------------
package nqse_pkg;

    localparam int MAX_QUEENS_DEF = 8;
    localparam int PACK_LIMIT     = 8;
    localparam int PACK_W         = 3;
    localparam int PLACE_W        = PACK_LIMIT * PACK_W;
    localparam int SIZE_W         = 4;
    localparam int ORD_W          = 12;

    localparam logic [SIZE_W-1:0] BOARD_RESET = SIZE_W'(8);
    localparam logic [ORD_W-1:0]  ORD_MAX     = {ORD_W{1'b1}};

    typedef struct packed {
        logic clr;
        logic zero;
        logic inc;
        logic placed;
    } t_cell_ctl;

endpackage
`default_nettype wire

### hdl/n_queens_solution_enumerator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator
// Depth-first N-queens search over a chain of column cells, one solution
// (or an exhausted flag) per request word.
// ----------------------------------------------------------------------------
// Flow: an accepted request word passes S_PREP, then takes search steps
//   (advance, retreat or next row) in S_SEARCH up to the result word.
// Throughput: one request at a time, none accepted until the result is
//   registered; one search step per cycle, the final step held while the
//   result register is stalled.
// Reset: synchronous, active low; clears the search, board size returns to 8.
// ----------------------------------------------------------------------------
module n_queens_solution_enumerator #(
    parameter int MAX_QUEENS = nqse_pkg::MAX_QUEENS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_restart,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [nqse_pkg::PLACE_W-1:0] o_placement,
    output logic                         o_found,
    output logic [nqse_pkg::ORD_W-1:0]   o_solution_ordinal,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [nqse_pkg::SIZE_W-1:0]  i_cfg_data
);

    localparam int SIZE_LIMIT = (MAX_QUEENS < nqse_pkg::PACK_LIMIT) ?
                                MAX_QUEENS : nqse_pkg::PACK_LIMIT;
    localparam int ROW_W      = $clog2(SIZE_LIMIT + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_PREP   = 3'b010,
        S_SEARCH = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [nqse_pkg::SIZE_W-1:0]   r_bsize, n_bsize;
    logic [ROW_W-1:0]              r_depth, n_depth;
    logic                          r_done, n_done;
    logic [nqse_pkg::ORD_W-1:0]    r_count, n_count;
    logic                          r_out_valid, n_out_valid;
    logic [nqse_pkg::PLACE_W-1:0]  r_placement, n_placement;
    logic                          r_found, n_found;
    logic [nqse_pkg::ORD_W-1:0]    r_ordinal, n_ordinal;

    nqse_pkg::t_cell_ctl           w_ctl   [SIZE_LIMIT];
    logic [ROW_W-1:0]              w_row   [SIZE_LIMIT];
    logic [SIZE_LIMIT-1:0]         w_cols  [SIZE_LIMIT+1];
    logic [SIZE_LIMIT-1:0]         w_ldiag [SIZE_LIMIT+1];
    logic [SIZE_LIMIT-1:0]         w_rdiag [SIZE_LIMIT+1];

    logic [ROW_W-1:0]              w_n;
    logic [ROW_W-1:0]              w_cur;
    logic [SIZE_LIMIT-1:0]         w_mask;
    logic                          w_safe;
    logic                          w_out_free;
    logic [nqse_pkg::ORD_W-1:0]    w_count_inc;
    logic [nqse_pkg::PLACE_W-1:0]  w_pack;

    assign w_cols[0]  = '0;
    assign w_ldiag[0] = '0;
    assign w_rdiag[0] = '0;

    for (genvar g = 0; g < SIZE_LIMIT; g++) begin : g_cell
        nqse_cell #(
            .ROWS  (SIZE_LIMIT),
            .ROW_W (ROW_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_cols  (w_cols[g]),
            .i_ldiag (w_ldiag[g]),
            .i_rdiag (w_rdiag[g]),
            .o_cols  (w_cols[g+1]),
            .o_ldiag (w_ldiag[g+1]),
            .o_rdiag (w_rdiag[g+1]),
            .o_row   (w_row[g])
        );
    end

    always_comb begin
        if (r_bsize == '0) begin
            w_n = ROW_W'(1);
        end else if (r_bsize > nqse_pkg::SIZE_W'(SIZE_LIMIT)) begin
            w_n = ROW_W'(SIZE_LIMIT);
        end else begin
            w_n = ROW_W'(r_bsize);
        end
    end

    always_comb begin
        w_cur  = '0;
        w_mask = '0;
        w_pack = '0;
        for (int c = 0; c < SIZE_LIMIT; c++) begin
            if (ROW_W'(c) == r_depth) begin
                w_cur  = w_row[c];
                w_mask = w_cols[c] | w_ldiag[c] | w_rdiag[c];
            end
            if (ROW_W'(c) < w_n) begin
                w_pack[c*nqse_pkg::PACK_W +: nqse_pkg::PACK_W] =
                    w_row[c][nqse_pkg::PACK_W-1:0];
            end
        end
    end

    assign w_safe      = ~|(w_mask & (SIZE_LIMIT'(1) << w_cur));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_count_inc = (r_count == nqse_pkg::ORD_MAX) ? r_count
                                                         : r_count + nqse_pkg::ORD_W'(1);

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;

    always_comb begin
        n_state     = r_state;
        n_bsize     = r_bsize;
        n_depth     = r_depth;
        n_done      = r_done;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_placement = r_placement;
        n_found     = r_found;
        n_ordinal   = r_ordinal;
        for (int c = 0; c < SIZE_LIMIT; c++) begin
            w_ctl[c]        = '0;
            w_ctl[c].placed = (ROW_W'(c) < r_depth);
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_bsize = i_cfg_data;
                    n_depth = '0;
                    n_done  = 1'b0;
                    n_count = '0;
                    for (int c = 0; c < SIZE_LIMIT; c++) w_ctl[c].clr = 1'b1;
                end else if (i_in_valid) begin
                    if (i_restart) begin
                        n_depth = '0;
                        n_done  = 1'b0;
                        n_count = '0;
                        for (int c = 0; c < SIZE_LIMIT; c++) w_ctl[c].clr = 1'b1;
                    end
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_done) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_placement = '0;
                        n_found     = 1'b0;
                        n_ordinal   = r_count;
                        n_state     = S_IDLE;
                    end
                end else begin
                    if (r_depth >= w_n) begin
                        n_depth = w_n - ROW_W'(1);
                        for (int c = 0; c < SIZE_LIMIT; c++) begin
                            if (ROW_W'(c) == w_n - ROW_W'(1)) w_ctl[c].inc = 1'b1;
                        end
                    end
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_cur >= w_n) begin
                    if (r_depth == '0) begin
                        if (w_out_free) begin
                            n_done      = 1'b1;
                            n_out_valid = 1'b1;
                            n_placement = '0;
                            n_found     = 1'b0;
                            n_ordinal   = r_count;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        n_depth = r_depth - ROW_W'(1);
                        for (int c = 0; c < SIZE_LIMIT; c++) begin
                            if (ROW_W'(c) == r_depth - ROW_W'(1)) w_ctl[c].inc = 1'b1;
                        end
                    end
                end else if (w_safe) begin
                    if (r_depth + ROW_W'(1) == w_n) begin
                        if (w_out_free) begin
                            n_depth     = w_n;
                            n_count     = w_count_inc;
                            n_out_valid = 1'b1;
                            n_placement = w_pack;
                            n_found     = 1'b1;
                            n_ordinal   = w_count_inc;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        n_depth = r_depth + ROW_W'(1);
                        for (int c = 0; c < SIZE_LIMIT; c++) begin
                            if (ROW_W'(c) == r_depth + ROW_W'(1)) w_ctl[c].zero = 1'b1;
                        end
                    end
                end else begin
                    for (int c = 0; c < SIZE_LIMIT; c++) begin
                        if (ROW_W'(c) == r_depth) w_ctl[c].inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bsize     <= nqse_pkg::BOARD_RESET;
            r_depth     <= '0;
            r_done      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bsize     <= n_bsize;
            r_depth     <= n_depth;
            r_done      <= n_done;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_placement <= n_placement;
        r_found     <= n_found;
        r_ordinal   <= n_ordinal;
    end

    assign o_out_valid        = r_out_valid;
    assign o_placement        = r_placement;
    assign o_found            = r_found;
    assign o_solution_ordinal = r_ordinal;

    a_depth_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_depth < w_n))
        else $error("search depth beyond board size");

    a_found_ordinal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_solution_ordinal != '0))
        else $error("solution given with zero ordinal");

    a_exhausted_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_placement == '0))
        else $error("exhausted result carries a placement");

    a_result_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state != S_IDLE))
        else $error("result raised without a search");

endmodule
`default_nettype wire

### hdl/nqse_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nqse_cell
// One board column: holds its queen row and extends the attacked-row masks
// handed on to the next column.
// ----------------------------------------------------------------------------
module nqse_cell #(
    parameter int ROWS  = 8,
    parameter int ROW_W = 4
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire nqse_pkg::t_cell_ctl i_ctl,
    input  wire  [ROWS-1:0]          i_cols,
    input  wire  [ROWS-1:0]          i_ldiag,
    input  wire  [ROWS-1:0]          i_rdiag,
    output logic [ROWS-1:0]          o_cols,
    output logic [ROWS-1:0]          o_ldiag,
    output logic [ROWS-1:0]          o_rdiag,
    output logic [ROW_W-1:0]         o_row
);

    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic [ROWS-1:0]  w_queen;

    always_comb begin
        n_row = r_row;
        if (i_ctl.clr || i_ctl.zero) begin
            n_row = '0;
        end else if (i_ctl.inc) begin
            n_row = r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign w_queen = i_ctl.placed ? (ROWS'(1) << r_row) : '0;
    assign o_cols  = i_cols | w_queen;
    assign o_ldiag = (i_ldiag | w_queen) << 1;
    assign o_rdiag = (i_rdiag | w_queen) >> 1;
    assign o_row   = r_row;

endmodule
`default_nettype wire
